[design/abt_pkg.sv]
package abt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ADDR_W = 16;
  localparam int HITS_W = 17;
  localparam int SKIP_W = 16;

  typedef enum logic [3:0] {
    FN_CHECK      = 4'd0,
    FN_ADD        = 4'd1,
    FN_REMOVE_IDX = 4'd2,
    FN_REMOVE_ADR = 4'd3,
    FN_MOVE       = 4'd4,
    FN_EN_IDX     = 4'd5,
    FN_EN_ADR     = 4'd6,
    FN_EN_ALL     = 4'd7,
    FN_IGNORE     = 4'd8,
    FN_SOFT_STOP  = 4'd9,
    FN_QUERY_IDX  = 4'd10,
    FN_QUERY_ADR  = 4'd11
  } func_t;

  typedef enum logic [1:0] {
    SS_OFF = 2'd0,
    SS_AT  = 2'd1,
    SS_ANY = 2'd2
  } ss_mode_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] address;
    logic [3:0]  index;
    logic [15:0] amount;
    logic        enable_value;
    logic        any_address;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic        op_ok;
    logic        found;
    logic        entry_enabled;
    logic [15:0] entry_address;
    logic [4:0]  entry_total;
    logic        needs_check;
  } out_item_t;

endpackage

[design/abt_queue.sv]
module abt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_valid,
  output logic                wr_stall,
  input  abt_pkg::in_item_t   wr_item,
  output logic                rd_valid,
  input  logic                rd_take,
  output abt_pkg::in_item_t   rd_item
);
  import abt_pkg::*;

  // two-entry fifo between front and back
  in_item_t   mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && rd_take;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && push) |=> rd_valid)
    else $error("pushed item not visible");
  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count mismatch");
endmodule

[design/abt_engine.sv]
module abt_engine #(
  parameter int CAPACITY = abt_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_take,
  input  abt_pkg::in_item_t   q_item,
  output logic                out_valid,
  input  logic                out_stall,
  output abt_pkg::out_item_t  out_data
);
  import abt_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int TW = $clog2(CAPACITY + 1);

  logic [ADDR_W-1:0] g_addr_r [CAPACITY];
  logic              g_en_r   [CAPACITY];
  logic [HITS_W-1:0] g_hits_r [CAPACITY];
  logic [SKIP_W-1:0] g_skip_r [CAPACITY];
  logic [TW-1:0]     total_r, total_nxt;
  logic [ADDR_W-1:0] ss_tgt_r;
  ss_mode_t          ss_mode_r, ss_mode_nxt;
  logic              flag_r, flag_nxt;
  logic              ov_r;
  out_item_t         od_r, od_nxt;

  logic [CAPACITY-1:0] match, live;
  logic                loc_hit;
  logic [IW-1:0]       loc_pos;
  logic                idx_ok, ss_fire;
  logic [IW-1:0]       idx;
  func_t               fn;
  logic                drop;
  logic [IW-1:0]       drop_pos;
  logic [HITS_W-1:0]   hnew;

  assign q_take    = q_valid && (!ov_r || !out_stall);
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign fn        = func_t'(q_item.func);
  assign idx       = IW'(q_item.index);
  assign idx_ok    = (32'(q_item.index) < 32'(total_r)) && (32'(q_item.index) < CAPACITY);
  assign ss_fire   = (ss_mode_r == SS_ANY) ||
                     (ss_mode_r == SS_AT && ss_tgt_r == q_item.address);

  // parallel comparators across the live entries
  always_comb begin
    loc_hit = 1'b0;
    loc_pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      live[i]  = (TW'(i) < total_r);
      match[i] = live[i] && (g_addr_r[i] == q_item.address);
    end
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        loc_hit = 1'b1;
        loc_pos = IW'(i);
      end
    end
  end

  assign hnew = (g_hits_r[loc_pos] == {HITS_W{1'b1}}) ? g_hits_r[loc_pos]
                                                       : g_hits_r[loc_pos] + HITS_W'(1);

  always_comb begin
    total_nxt   = total_r;
    ss_mode_nxt = ss_mode_r;
    flag_nxt    = flag_r;
    drop        = 1'b0;
    drop_pos    = '0;
    od_nxt      = '0;
    unique case (fn)
      FN_CHECK: begin
        od_nxt.op_ok = 1'b1;
        if (ss_fire) begin
          ss_mode_nxt = SS_OFF;
          flag_nxt    = (total_r != '0);
          od_nxt.hit  = 1'b1;
        end else if (loc_hit && g_en_r[loc_pos]) begin
          od_nxt.hit = (hnew > HITS_W'(g_skip_r[loc_pos]));
        end
      end
      FN_ADD: begin
        if (!loc_hit && 32'(total_r) < CAPACITY) begin
          total_nxt    = total_r + TW'(1);
          flag_nxt     = 1'b1;
          od_nxt.op_ok = 1'b1;
        end
      end
      FN_REMOVE_IDX: begin
        if (idx_ok) begin
          drop         = 1'b1;
          drop_pos     = idx;
          total_nxt    = total_r - TW'(1);
          flag_nxt     = (total_nxt != '0);
          od_nxt.op_ok = 1'b1;
        end
      end
      FN_REMOVE_ADR: begin
        if (loc_hit) begin
          drop         = 1'b1;
          drop_pos     = loc_pos;
          total_nxt    = total_r - TW'(1);
          od_nxt.op_ok = 1'b1;
        end
        flag_nxt = (total_nxt != '0);
      end
      FN_MOVE:      od_nxt.op_ok = idx_ok && !loc_hit;
      FN_EN_IDX:    od_nxt.op_ok = idx_ok;
      FN_EN_ADR:    od_nxt.op_ok = loc_hit;
      FN_EN_ALL:    od_nxt.op_ok = 1'b1;
      FN_IGNORE:    od_nxt.op_ok = idx_ok;
      FN_SOFT_STOP: begin
        ss_mode_nxt  = q_item.any_address ? SS_ANY : SS_AT;
        flag_nxt     = 1'b1;
        od_nxt.op_ok = 1'b1;
      end
      FN_QUERY_IDX: begin
        if (idx_ok) begin
          od_nxt.op_ok         = 1'b1;
          od_nxt.found         = 1'b1;
          od_nxt.entry_enabled = g_en_r[idx];
          od_nxt.entry_address = g_addr_r[idx];
        end
      end
      FN_QUERY_ADR: begin
        if (loc_hit) begin
          od_nxt.op_ok         = 1'b1;
          od_nxt.found         = 1'b1;
          od_nxt.entry_enabled = g_en_r[loc_pos];
          od_nxt.entry_address = g_addr_r[loc_pos];
        end
      end
      default: ;
    endcase
    od_nxt.entry_total = 5'(total_nxt);
    od_nxt.needs_check = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      ss_mode_r <= SS_OFF;
      ss_tgt_r  <= '0;
      flag_r    <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      if (q_take) begin
        total_r   <= total_nxt;
        ss_mode_r <= ss_mode_nxt;
        flag_r    <= flag_nxt;
        if (fn == FN_SOFT_STOP) ss_tgt_r <= q_item.address;
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      od_r <= od_nxt;
      for (int i = 0; i < CAPACITY; i++) begin
        if (drop && IW'(i) >= drop_pos && i + 1 < CAPACITY) begin
          g_addr_r[i] <= g_addr_r[(i + 1) % CAPACITY];
          g_en_r[i]   <= g_en_r[(i + 1) % CAPACITY];
          g_hits_r[i] <= g_hits_r[(i + 1) % CAPACITY];
          g_skip_r[i] <= g_skip_r[(i + 1) % CAPACITY];
        end
        if (fn == FN_EN_ALL && live[i]) g_en_r[i] <= q_item.enable_value;
      end
      unique case (fn)
        FN_CHECK: if (!ss_fire && loc_hit && g_en_r[loc_pos]) g_hits_r[loc_pos] <= hnew;
        FN_ADD: if (od_nxt.op_ok) begin
          g_addr_r[IW'(total_r)] <= q_item.address;
          g_en_r[IW'(total_r)]   <= 1'b1;
          g_hits_r[IW'(total_r)] <= '0;
          g_skip_r[IW'(total_r)] <= q_item.amount;
        end
        FN_MOVE: if (od_nxt.op_ok) begin
          g_addr_r[idx] <= q_item.address;
          g_hits_r[idx] <= '0;
        end
        FN_EN_IDX: if (idx_ok) g_en_r[idx] <= q_item.enable_value;
        FN_EN_ADR: if (loc_hit) g_en_r[loc_pos] <= q_item.enable_value;
        FN_IGNORE: if (idx_ok) g_skip_r[idx] <= q_item.amount;
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) 32'(total_r) <= CAPACITY)
    else $error("table count beyond capacity");
  assert property (@(posedge clk) disable iff (!rst_n) q_valid |-> $onehot0(match))
    else $error("duplicate address in table");
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_take && fn == FN_CHECK && ss_fire) |=> ss_mode_r == SS_OFF)
    else $error("soft stop did not disarm");
endmodule

[design/address_breakpoint_table.sv]
// Breakpoint and watchpoint guard table with one soft stop. Each item is a command
// (check, add, remove, move, enable, ignore count, soft stop, query) and yields
// exactly one result. The front is a two-entry queue; the back compares the address
// against every live entry in parallel and commits each item as it takes it, so one
// item is taken per cycle when the output is not stalled. The result is registered
// in the engine's output register and holds while out_stall is high.
// Removal shifts the table down at the same edge that registers the result.
module address_breakpoint_table #(
  parameter int CAPACITY = abt_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  abt_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output abt_pkg::out_item_t  out_data
);
  import abt_pkg::*;

  // queue to engine
  logic     q_valid, q_take;
  in_item_t q_item;

  abt_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_stall(in_stall), .wr_item(in_data),
    .rd_valid(q_valid), .rd_take(q_take), .rd_item(q_item)
  );

  abt_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_take(q_take), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );
endmodule
